// ===== src/crc16p_pkg.sv =====
package crc16p_pkg;

  localparam int CRC_W  = 16;
  localparam int BYTE_W = 8;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Register indexes (paddr[2])
  localparam logic REG_POLY = 1'b0;
  localparam logic REG_INIT = 1'b1;

  localparam logic [CRC_W-1:0] POLY_RST = 16'h1021;
  localparam logic [CRC_W-1:0] INIT_RST = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_RST  = 16'hFFFF;

  typedef struct packed {
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] init;
  } cfg_t;

endpackage

// ===== src/crc16p_regs.sv =====
module crc16p_regs
  import crc16p_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [CRC_W-1:0] poly_r;
  logic [CRC_W-1:0] init_r;
  logic             wr_en;
  logic             idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  // Low address bits ignored: word select only
  assign idx        = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RST;
      init_r <= INIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_POLY: poly_r <= cfg_pwdata[CRC_W-1:0];
        REG_INIT: init_r <= cfg_pwdata[CRC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POLY: cfg_prdata = {{(APB_DW-CRC_W){1'b0}}, poly_r};
      REG_INIT: cfg_prdata = {{(APB_DW-CRC_W){1'b0}}, init_r};
      default:  cfg_prdata = '0;
    endcase
  end

  assign cfg.poly = poly_r;
  assign cfg.init = init_r;

endmodule

// ===== src/crc16p_fold.sv =====
module crc16p_fold
  import crc16p_pkg::*;
(
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [BYTE_W-1:0] data,
  input  logic [CRC_W-1:0]  poly,
  output logic [CRC_W-1:0]  crc_out
);

  // Eight MSB-first division steps on the byte XORed into the top half.
  always_comb begin
    logic [CRC_W-1:0] r;
    r = {crc_in[CRC_W-1:BYTE_W] ^ data, {BYTE_W{1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    crc_out = r ^ {crc_in[BYTE_W-1:0], {BYTE_W{1'b0}}};
  end

endmodule

// ===== src/crc16_programmable_poly_bytewise_top.sv =====
// Channel | Dir | Transfer when           | Contents
// in_     | in  | in_tvalid & in_tready   | tdata: data_byte, tuser: start_of_message
// out_    | out | out_tvalid & out_tready | tdata: crc_value
// cfg_    | in  | psel&penable&pwrite     | APB, 0x0 polynomial, 0x4 initial value
//
// One byte per cycle sustained while the output is not stalled.
// Path: input register -> eight-step XOR fold against the running CRC -> result register.
// Synchronous active-low reset clears valids, restores register defaults and sets CRC to all ones.
// Output stall backs up into the input register; in_tready drops only when both are full.
module crc16_programmable_poly_bytewise_top
  import crc16p_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic              in_tuser,   // [0] start_of_message
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CRC_W-1:0]  out_tdata,  // [15:0] crc_value
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;

  // Input register
  logic              s1_vld_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_sof_r;

  // Result register and running state
  logic              out_vld_r;
  logic [CRC_W-1:0]  out_crc_r;
  logic [CRC_W-1:0]  crc_r;

  logic              out_free;
  logic              s1_move;
  logic              in_xfer;
  logic [CRC_W-1:0]  crc_base;
  logic [CRC_W-1:0]  crc_nxt;

  crc16p_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign out_free  = ~out_vld_r | out_tready;
  assign s1_move   = s1_vld_r & out_free;
  assign in_tready = ~s1_vld_r | s1_move;
  assign in_xfer   = in_tvalid & in_tready;

  // Start of message restarts from the configured seed
  assign crc_base = s1_sof_r ? cfg.init : crc_r;

  crc16p_fold u_fold (
    .crc_in  (crc_base),
    .data    (s1_byte_r),
    .poly    (cfg.poly),
    .crc_out (crc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata;
      s1_sof_r  <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      crc_r     <= CRC_RST;
    end else begin
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
      if (s1_move) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_crc_r <= crc_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_crc_r;

endmodule

// ===== src/crc16p_checker.sv =====
module crc16p_checker
  import crc16p_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [CRC_W-1:0]  out_tdata
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Stalled result data is stable
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // Every input transfer is followed by a valid result at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("accepted byte produced no result");

  // An empty result register never backs up the input
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind crc16_programmable_poly_bytewise_top crc16p_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
